// ===== hdl/run_segment_image_moments_macros.svh =====
// Assertion macros used by the checker of the moments block.
`ifndef RUN_SEGMENT_IMAGE_MOMENTS_MACROS_SVH
`define RUN_SEGMENT_IMAGE_MOMENTS_MACROS_SVH

// Plain property, sampled on the rising clock and quiet while reset is held.
`define RSIM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define RSIM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/rsim_pkg.sv =====
// Shared widths, constants and types of the run segment image moments block.
`timescale 1ns / 1ps
`default_nettype none

package rsim_pkg;

	localparam int CB = 10;

	localparam int LEN_W   = CB + 1;
	localparam int DIFF_W  = CB + 1;
	localparam int TRI_W   = 2 * CB + 1;
	localparam int SQ_W    = 2 * CB;
	localparam int LD_W    = 2 * CB + 3;
	localparam int S1_W    = 2 * CB + 2;
	localparam int CUBE_W  = 3 * CB + 1;
	localparam int PROD3_W = 3 * CB + 2;
	localparam int DT_W    = 3 * CB + 4;
	localparam int C11S_W  = 3 * CB + 4;

	localparam int W_AREA = 2 * CB + 1;
	localparam int W_M1   = 3 * CB + 1;
	localparam int W_C11  = 4 * CB + 2;
	localparam int W_C2   = 4 * CB + 1;

	localparam int IN_W      = 5 * CB + 1;
	localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W      = W_AREA + 2 * W_M1 + W_C11 + 2 * W_C2;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int BACK_STAGES = 4;
	// Items that may sit between the input port and the output register.
	localparam int PIPE_CAP    = 1 + QUEUE_DEPTH + BACK_STAGES + 1;
	localparam int PEND_W      = $clog2(PIPE_CAP + 1);

	// Inverse of three modulo 2^PROD3_W; exact division of a multiple of three.
	localparam longint unsigned INV3_FULL = (PROD3_W % 2 == 0) ?
		(((64'd1 << (PROD3_W + 1)) + 64'd1) / 64'd3) :
		(((64'd1 << PROD3_W) + 64'd1) / 64'd3);
	localparam logic [PROD3_W-1:0] INV3 = PROD3_W'(INV3_FULL);

	typedef struct packed {
		logic [CB-1:0]            x;
		logic [CB-1:0]            a;
		logic [LEN_W-1:0]         len;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy0;
		logic                     last;
	} seg_item_t;

	typedef struct packed {
		logic      push;
		seg_item_t item;
	} q_wr_t;

	typedef struct packed {
		logic      valid;
		seg_item_t item;
	} q_rd_t;

	// Declared from the top field down, so the area lands in the lowest bits.
	typedef struct packed {
		logic [W_C2-1:0]   cmom_02;
		logic [W_C2-1:0]   cmom_20;
		logic [W_C11-1:0]  cmom_11;
		logic [W_M1-1:0]   mom_m01;
		logic [W_M1-1:0]   mom_m10;
		logic [W_AREA-1:0] area_m00;
	} moments_t;

endpackage

`default_nettype wire

// ===== hdl/run_segment_image_moments.sv =====
// Top level of the run segment image moments block.
//
// The block takes one vertical run segment per item (column, first row, length,
// region centroid, and tlast on the final segment of a region) and accumulates
// the area m00, the first moments m10 and m01, and the central moments cm11,
// cm20 and cm02 about the given centroid, all in exact integer arithmetic. The
// row sums of a segment use closed forms, so a segment costs the same however
// long it is. On the segment that carries tlast, one result item leaves on the
// master side holding all six sums including that segment, and the
// accumulators start again from zero; other segments produce no result. Every
// sum wraps modulo two to the power of its field width. While the master side
// does not stall, the block sustains one segment per clock: a front register
// accepts and unpacks segments, a four-entry queue hands them to a four-stage
// product pipeline, and a single accumulator stage adds one segment per cycle.
// A result passes through the front register, the queue and the product stages
// into the result register before it is offered. Backpressure on the master
// side holds the product pipeline; the queue and the front register keep taking
// segments until they are full. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module run_segment_image_moments
	import rsim_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// seg_x, seg_y, seg_len, cent_x, cent_y from bit 0 up, then zero fill
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// seg_last
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// area_m00, mom_m10, mom_m01, cmom_11, cmom_20, cmom_02 from bit 0 up, then zero fill
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	q_wr_t    q_wr;
	q_rd_t    q_rd;
	logic     q_full;
	logic     q_pop;
	moments_t result;

	// Front end: one register of unpacked segments with centroid offsets.
	rsim_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.wr       (q_wr),
		.q_full   (q_full)
	);

	// The queue lets the front keep accepting while the back end is stalled.
	rsim_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.rd     (q_rd),
		.pop    (q_pop)
	);

	// Back end: products, accumulation and the result register.
	rsim_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (q_rd),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - OUT_W){1'b0}}, result};

endmodule

`default_nettype wire

// ===== hdl/rsim_front.sv =====
// Front end: input register that unpacks a segment and forms its centroid offsets.
`timescale 1ns / 1ps
`default_nettype none

module rsim_front
	import rsim_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [IN_DATA_W-1:0] in_data,
	input  wire logic                 in_last,
	output q_wr_t                     wr,
	input  wire logic                 q_full
);

	logic      valid_q;
	seg_item_t item_q;
	seg_item_t item_d;
	logic      push;

	always_comb begin
		item_d.x    = in_data[CB-1:0];
		item_d.a    = in_data[2*CB-1:CB];
		item_d.len  = in_data[3*CB:2*CB];
		// Offsets from the centroid, one bit wider so they stay signed.
		item_d.dx   = $signed({1'b0, in_data[CB-1:0]}) - $signed({1'b0, in_data[4*CB:3*CB+1]});
		item_d.dy0  = $signed({1'b0, in_data[2*CB-1:CB]}) - $signed({1'b0, in_data[5*CB:4*CB+1]});
		item_d.last = in_last;
	end

	assign push     = valid_q && !q_full;
	assign in_ready = !valid_q || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_d;
		end
	end

	assign wr.push = push;
	assign wr.item = item_q;

endmodule

`default_nettype wire

// ===== hdl/rsim_queue.sv =====
// Small flop-based FIFO that decouples the front end from the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module rsim_queue
	import rsim_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  q_wr_t      wr,
	output logic       full,
	output q_rd_t      rd,
	input  wire logic  pop
);

	seg_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.item  = mem_q[rd_ptr_q];
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && rd.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.item;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rsim_back.sv =====
// Back end: four product stages, the moment accumulators and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rsim_back
	import rsim_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  q_rd_t     rd,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output moments_t  out_data
);

	logic adv;

	// Stage 1: triangular number of the length and the column product.
	logic [LEN_W-1:0]     lenm1;
	logic [2*LEN_W-1:0]   tri_prod;
	logic                 v_s1, last_s1;
	logic [CB-1:0]        a_s1;
	logic [LEN_W-1:0]     len_s1;
	logic signed [DIFF_W-1:0] dx_s1, d_s1;
	logic [TRI_W-1:0]     tri_s1;
	logic [TRI_W-1:0]     xlen_s1;

	// Stage 2: products of offsets and lengths.
	logic [LEN_W:0]              twolm1;
	logic signed [2*DIFF_W-1:0]  d2_full, dx2_full;
	logic signed [LD_W-1:0]      len_ld, d_ld;
	logic                        v_s2, last_s2;
	logic [LEN_W-1:0]            len_s2;
	logic [TRI_W-1:0]            la_s2, tri_s2, xlen_s2;
	logic signed [LD_W-1:0]      ld_s2;
	logic signed [DIFF_W-1:0]    d_s2, dx_s2;
	logic [SQ_W-1:0]             d2_s2, dx2_s2;
	logic [PROD3_W-1:0]          p_s2;

	// Stage 3: row sums and second order terms.
	logic signed [DT_W-1:0]   tri2_dt, d_dt;
	logic                     v_s3, last_s3;
	logic [LEN_W-1:0]         len_s3;
	logic [TRI_W-1:0]         xlen_s3;
	logic [S1_W-1:0]          s1sum_s3;
	logic signed [LD_W-1:0]   dy_s3;
	logic signed [DIFF_W-1:0] dx_s3;
	logic [CUBE_W-1:0]        ld2_s3, c20_s3;
	logic signed [DT_W-1:0]   dt_s3;
	logic [PROD3_W-1:0]       t2_s3;

	// Stage 4: mixed moment product and row central moment sum.
	logic                     v_s4, last_s4;
	logic [LEN_W-1:0]         len_s4;
	logic [TRI_W-1:0]         xlen_s4;
	logic [S1_W-1:0]          s1sum_s4;
	logic signed [C11S_W-1:0] c11_s4;
	logic [CUBE_W-1:0]        c20_s4;
	logic [W_C2-1:0]          c02_s4;

	// Accumulators and result register.
	logic [W_AREA-1:0] acc_area_q, area_n;
	logic [W_M1-1:0]   acc_m10_q, acc_m01_q, m10_n, m01_n;
	logic [W_C11-1:0]  acc_c11_q, c11_n;
	logic [W_C2-1:0]   acc_c20_q, acc_c02_q, c20_n, c02_n;
	logic              out_valid_q;
	moments_t          out_q;

	// The whole back end moves unless a finished result is waiting and stalled.
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && rd.valid;

	assign lenm1    = rd.item.len - 1'b1;
	assign tri_prod = (2*LEN_W)'(rd.item.len) * (2*LEN_W)'(lenm1);

	assign twolm1   = {len_s1, 1'b0} - 1'b1;
	assign d2_full  = d_s1 * d_s1;
	assign dx2_full = dx_s1 * dx_s1;
	assign len_ld   = $signed(LD_W'(len_s1));
	assign d_ld     = LD_W'(d_s1);

	assign tri2_dt  = $signed(DT_W'({tri_s2, 1'b0}));
	assign d_dt     = DT_W'(d_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= rd.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= rd.item.last;
			a_s1    <= rd.item.a;
			len_s1  <= rd.item.len;
			dx_s1   <= rd.item.dx;
			d_s1    <= rd.item.dy0;
			tri_s1  <= tri_prod[TRI_W:1];
			xlen_s1 <= TRI_W'(rd.item.x) * TRI_W'(rd.item.len);

			last_s2 <= last_s1;
			len_s2  <= len_s1;
			la_s2   <= TRI_W'(a_s1) * TRI_W'(len_s1);
			ld_s2   <= len_ld * d_ld;
			d_s2    <= d_s1;
			dx_s2   <= dx_s1;
			d2_s2   <= d2_full[SQ_W-1:0];
			dx2_s2  <= dx2_full[SQ_W-1:0];
			tri_s2  <= tri_s1;
			xlen_s2 <= xlen_s1;
			// Product of the triangular number and 2L-1, kept modulo 2^PROD3_W.
			p_s2    <= PROD3_W'(tri_s1) * PROD3_W'(twolm1);

			last_s3  <= last_s2;
			len_s3   <= len_s2;
			xlen_s3  <= xlen_s2;
			s1sum_s3 <= S1_W'(la_s2) + S1_W'(tri_s2);
			dy_s3    <= ld_s2 + $signed(LD_W'(tri_s2));
			dx_s3    <= dx_s2;
			ld2_s3   <= CUBE_W'(len_s2) * CUBE_W'(d2_s2);
			dt_s3    <= tri2_dt * d_dt;
			// Sum of squares below L: exact division by three via the modular inverse.
			t2_s3    <= p_s2 * INV3;
			c20_s3   <= CUBE_W'(len_s2) * CUBE_W'(dx2_s2);

			last_s4  <= last_s3;
			len_s4   <= len_s3;
			xlen_s4  <= xlen_s3;
			s1sum_s4 <= s1sum_s3;
			c11_s4   <= C11S_W'(dx_s3) * C11S_W'(dy_s3);
			c20_s4   <= c20_s3;
			c02_s4   <= W_C2'(ld2_s3) + W_C2'(dt_s3) + W_C2'(t2_s3);
		end
	end

	always_comb begin
		area_n = acc_area_q + W_AREA'(len_s4);
		m10_n  = acc_m10_q + W_M1'(xlen_s4);
		m01_n  = acc_m01_q + W_M1'(s1sum_s4);
		c11_n  = acc_c11_q + W_C11'(c11_s4);
		c20_n  = acc_c20_q + W_C2'(c20_s4);
		c02_n  = acc_c02_q + c02_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_area_q  <= '0;
			acc_m10_q   <= '0;
			acc_m01_q   <= '0;
			acc_c11_q   <= '0;
			acc_c20_q   <= '0;
			acc_c02_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s4 && last_s4;
			if (v_s4 && last_s4) begin
				acc_area_q <= '0;
				acc_m10_q  <= '0;
				acc_m01_q  <= '0;
				acc_c11_q  <= '0;
				acc_c20_q  <= '0;
				acc_c02_q  <= '0;
			end else if (v_s4) begin
				acc_area_q <= area_n;
				acc_m10_q  <= m10_n;
				acc_m01_q  <= m01_n;
				acc_c11_q  <= c11_n;
				acc_c20_q  <= c20_n;
				acc_c02_q  <= c02_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4 && last_s4) begin
			out_q.area_m00 <= area_n;
			out_q.mom_m10  <= m10_n;
			out_q.mom_m01  <= m01_n;
			out_q.cmom_11  <= c11_n;
			out_q.cmom_20  <= c20_n;
			out_q.cmom_02  <= c02_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== hdl/rsim_checker.sv =====
// Port-level checker for the run segment image moments block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "run_segment_image_moments_macros.svh"

module rsim_checker
	import rsim_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  s_axis_tlast,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [PEND_W-1:0] pending_q;
	logic              last_in;
	logic              res_out;

	// Regions whose last segment went in but whose result has not come out.
	assign last_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign res_out = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !res_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_out && !last_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`RSIM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")

	`RSIM_ASSERT(a_result_has_region, !m_axis_tvalid || (pending_q != '0),
		"result offered without a closed region")

	`RSIM_ASSERT(a_pending_bounded, pending_q <= PEND_W'(PIPE_CAP),
		"more open results than the block can hold")

endmodule

bind run_segment_image_moments rsim_checker u_rsim_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
